// File: src/sbpf_pkg.sv
// shared types and constants of the servo bus packet framer
package sbpf_pkg;

    localparam int FRAME_MAX = 7;
    localparam int CNT_W     = $clog2(FRAME_MAX + 1);

    localparam logic [7:0] SYNC_MARK          = 8'hFF;
    localparam logic [7:0] BROADCAST_ID       = 8'hFE;
    localparam logic [7:0] PLAIN_LEN_NO_PARAM = 8'd2;
    localparam logic [7:0] PLAIN_LEN_EXTRA    = 8'd3;
    localparam logic [7:0] SYNC_LEN_EXTRA     = 8'd4;
    localparam logic [7:0] SYNC_OPCODE_RESET  = 8'd131;

    typedef enum logic [1:0] {
        CMD_PLAIN    = 2'd0,
        CMD_SYNC     = 2'd1,
        CMD_DATA     = 2'd2,
        CMD_SERVO_ID = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] servo_id;
        logic [7:0] instruction;
        logic [7:0] mem_address;
        logic [7:0] param_count;
        logic [7:0] servo_count;
        logic [7:0] data_byte;
        logic       last_item;
    } item_t;

    typedef struct packed {
        logic [FRAME_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      has_chk;
    } frame_t;

endpackage

// File: src/sbpf_if.sv
// item and result channel interfaces of the servo bus packet framer
interface sbpf_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] servo_id;
    logic [7:0] instruction;
    logic [7:0] mem_address;
    logic [7:0] param_count;
    logic [7:0] servo_count;
    logic [7:0] data_byte;
    logic       last_item;

    modport source (
        output valid, command, servo_id, instruction, mem_address,
               param_count, servo_count, data_byte, last_item,
        input  ready
    );
    modport sink (
        input  valid, command, servo_id, instruction, mem_address,
               param_count, servo_count, data_byte, last_item,
        output ready
    );
endinterface

interface sbpf_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       is_checksum;

    modport source (
        output valid, tx_byte, last_byte, is_checksum,
        input  ready
    );
    modport sink (
        input  valid, tx_byte, last_byte, is_checksum,
        output ready
    );
endinterface

// File: src/sbpf_builder.sv
// header and payload byte builder with running checksum and packet state
module sbpf_builder
    import sbpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      item,
    input  logic       take,
    input  logic [7:0] sync_opcode,
    output frame_t     frame
);

    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic       open_reg;
    logic       open_next;

    logic [7:0] plain_len;
    logic [7:0] sync_len;
    logic [7:0] sync_prod;
    logic [7:0] pay_byte;
    logic [7:0] chk;
    logic       has_param;

    always_comb
    begin
        has_param = (item.param_count != 8'd0);
        plain_len = has_param ? (item.param_count + PLAIN_LEN_EXTRA) : PLAIN_LEN_NO_PARAM;
        sync_prod = 8'((item.param_count + 8'd1) * item.servo_count);
        sync_len  = sync_prod + SYNC_LEN_EXTRA;
        pay_byte  = (item.command == CMD_DATA) ? item.data_byte : item.servo_id;

        sum_next  = sum_reg;
        open_next = open_reg;
        frame     = '0;

        case (item.command)
            CMD_PLAIN:
            begin
                sum_next = item.servo_id + plain_len + item.instruction + item.mem_address;
                open_next = !item.last_item;
            end
            CMD_SYNC:
            begin
                sum_next = BROADCAST_ID + sync_len + sync_opcode + item.mem_address
                           + item.param_count;
                open_next = 1'b1;
            end
            default:
            begin
                if (open_reg)
                begin
                    sum_next  = sum_reg + pay_byte;
                    open_next = !item.last_item;
                end
            end
        endcase

        chk = ~sum_next;

        case (item.command)
            CMD_PLAIN:
            begin
                frame.bytes[0] = SYNC_MARK;
                frame.bytes[1] = SYNC_MARK;
                frame.bytes[2] = item.servo_id;
                frame.bytes[3] = plain_len;
                frame.bytes[4] = item.instruction;
                frame.bytes[5] = has_param ? item.mem_address : chk;
                frame.bytes[6] = chk;
                frame.count    = CNT_W'(5) + CNT_W'(has_param) + CNT_W'(item.last_item);
                frame.has_chk  = item.last_item;
            end
            CMD_SYNC:
            begin
                frame.bytes[0] = SYNC_MARK;
                frame.bytes[1] = SYNC_MARK;
                frame.bytes[2] = BROADCAST_ID;
                frame.bytes[3] = sync_len;
                frame.bytes[4] = sync_opcode;
                frame.bytes[5] = item.mem_address;
                frame.bytes[6] = item.param_count;
                frame.count    = CNT_W'(FRAME_MAX);
                frame.has_chk  = 1'b0;
            end
            default:
            begin
                frame.bytes[0] = pay_byte;
                frame.bytes[1] = chk;
                frame.count    = open_reg ? (CNT_W'(1) + CNT_W'(item.last_item)) : '0;
                frame.has_chk  = item.last_item;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            open_reg <= 1'b0;
        end
        else if (take)
        begin
            sum_reg  <= sum_next;
            open_reg <= open_next;
        end
    end

endmodule

// File: src/sbpf_emitter.sv
// frame register that sends its bytes one beat at a time
module sbpf_emitter
    import sbpf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  frame_t        frame,
    input  logic          load,
    output logic          free,
    sbpf_result_if.source result
);

    frame_t           frame_reg;
    logic             valid_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             at_last;

    assign at_last = (idx_reg == (frame_reg.count - CNT_W'(1)));
    assign free    = !valid_reg || (result.ready && at_last);

    assign result.valid       = valid_reg;
    assign result.tx_byte     = frame_reg.bytes[idx_reg];
    assign result.last_byte   = at_last;
    assign result.is_checksum = at_last && frame_reg.has_chk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= (frame.count != '0);
            idx_reg   <= '0;
        end
        else if (valid_reg && result.ready)
        begin
            if (at_last)
            begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= frame;
        end
    end

endmodule

// File: src/servo_bus_packet_framer.sv
// top level of the servo bus packet framer
// Builds servo bus packets as a byte stream, one byte per result beat. An item
// waits in the input register until the emitter is free, is expanded into its
// bytes in one pass and sent from the frame register at up to one byte per
// cycle while the result channel is ready. Headers yield 5 to 7 bytes, payload
// items 1 or 2 in an open packet and none otherwise. The next item is taken as
// the last byte of the previous one goes out, so one-byte payload items flow at
// one per cycle while the result channel is ready.
module servo_bus_packet_framer
    import sbpf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [7:0]    cfg_wr_data,
    sbpf_item_if.sink     item,
    sbpf_result_if.source result
);

    logic [7:0] sync_opcode_reg;
    item_t      item_reg;
    logic       item_valid_reg;
    logic       take;
    logic       free;
    frame_t     frame;

    assign take       = item_valid_reg && free;
    assign item.ready = !item_valid_reg || free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_opcode_reg <= SYNC_OPCODE_RESET;
        end
        else if (cfg_wr_en)
        begin
            sync_opcode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item.valid && item.ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg.command     <= cmd_t'(item.command);
            item_reg.servo_id    <= item.servo_id;
            item_reg.instruction <= item.instruction;
            item_reg.mem_address <= item.mem_address;
            item_reg.param_count <= item.param_count;
            item_reg.servo_count <= item.servo_count;
            item_reg.data_byte   <= item.data_byte;
            item_reg.last_item   <= item.last_item;
        end
    end

    sbpf_builder u_builder (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_reg),
        .take        (take),
        .sync_opcode (sync_opcode_reg),
        .frame       (frame)
    );

    sbpf_emitter u_emitter (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame),
        .load   (take),
        .free   (free),
        .result (result)
    );

endmodule
